// File: hw/rtl/srlsu_pkg.sv
// Package for the shift/rotate/load/store unit.
// Holds sizes, the operation codes, the instruction and result types and small helpers.
// No dependencies.
package srlsu_pkg;

	// Storage sizes
	localparam int REG_COUNT  = 7;
	localparam int MEM_WORDS  = 64;
	localparam int DATA_WIDTH = 8;
	localparam int REG_AW     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam int MEM_AW     = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	// Field widths of a transaction
	localparam int IDX_W   = 3;
	localparam int SHIFT_W = 3;
	localparam int DADDR_W = 6;
	localparam int CNT_W   = 16;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 32;

	// Memory word that comes out of reset nonzero
	localparam int RESET_WORD     = 28;
	localparam int RESET_WORD_VAL = 4;

	// Output queue
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_CW    = 3;

	typedef enum logic [2:0] {
		MODE_SHL   = 3'd0,
		MODE_SHR   = 3'd1,
		MODE_ROL   = 3'd2,
		MODE_ROR   = 3'd3,
		MODE_LOAD  = 3'd4,
		MODE_STORE = 3'd5
	} mode_t;

	typedef logic [DATA_WIDTH-1:0] data_t;

	typedef struct packed {
		logic [IDX_W-1:0]   addr_reg;
		logic [DADDR_W-1:0] direct_addr;
		logic               use_indirect;
		logic [SHIFT_W-1:0] shift_amount;
		logic [IDX_W-1:0]   target_reg;
		mode_t              mode;
	} instr_t;

	typedef struct packed {
		logic [CNT_W-1:0] executed_count;
		logic             addr_error;
		data_t            moved_value;
	} result_t;

	// Register file write record
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		data_t            data;
	} reg_wr_t;

	function automatic logic reg_in_range(logic [IDX_W-1:0] idx);
		return int'(idx) < REG_COUNT;
	endfunction

	function automatic logic [REG_AW-1:0] reg_addr(logic [IDX_W-1:0] idx);
		return REG_AW'(idx);
	endfunction

	function automatic data_t mem_reset_val(logic [MEM_AW-1:0] addr);
		return (int'(addr) == RESET_WORD) ? data_t'(RESET_WORD_VAL) : '0;
	endfunction

endpackage

// File: hw/rtl/shift_rotate_load_store_unit_core.sv
// Shift/rotate/load/store unit: executes one decoded instruction per transaction.
// Register file and data memory are synchronous arrays with read-modify-write forwarding.
// Depends on srlsu_pkg.
//
// Usage:
//   Slave channel (s_tvalid/s_tready/s_tdata) carries one instruction per transaction.
//   Master channel (m_tvalid/m_tready/m_tdata) returns exactly one result per instruction,
//   in order: the moved byte, the address error flag and the executed-instruction count.
//   Throughput: one instruction per cycle while s_tready is high. Each instruction passes
//   the register file read (stage 1) and the data memory read (stage 2), and its result
//   is then written into the result queue, from which m_tvalid rises. Writes land
//   at the end of the second stage, and both arrays forward pending writes to younger
//   instructions, so back-to-back dependent instructions need no interlock.
//   A 4-entry result queue sits at the output. s_tready drops once queued plus in-flight
//   results would fill it, so a stalled receiver never loses a result and the pipeline
//   itself never stalls.
//   Reset (arst_n low) clears the pipeline, the queue and the counter, and marks every
//   register and memory word unwritten: registers read as zero, memory words read as
//   zero except word 28, which reads as 4. No clearing pass is needed after reset.
module shift_rotate_load_store_unit_core
	import srlsu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	// s_tdata: mode[2:0], target_reg[5:3], shift_amount[8:6], use_indirect[9],
	//          direct_addr[15:10], addr_reg[18:16], zero[23:19]
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,
	// m_tdata: moved_value[7:0], addr_error[8], executed_count[24:9], zero[31:25]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata
);

	// Storage
	data_t                 rf_mem [REG_COUNT];
	logic [REG_COUNT-1:0]  rf_vld_q;
	data_t                 dmem [MEM_WORDS];
	logic [MEM_WORDS-1:0]  dmem_vld_q;

	// Input decode
	instr_t in_ins;
	logic   in_acc;

	// Stage 1
	logic   s1_v;
	instr_t ins_s1;
	data_t  rt_raw_s1, ra_raw_s1;
	logic   rt_vld_s1, ra_vld_s1;
	data_t  v_tgt, v_areg;
	data_t  shres;
	logic [DATA_WIDTH-1:0] addr_full;
	logic   addr_err;
	logic [2*DATA_WIDTH-1:0] dbl;

	// Stage 2
	logic   s2_v;
	mode_t  mode_s2;
	logic [IDX_W-1:0]  tgt_s2;
	logic [MEM_AW-1:0] addr_s2;
	logic   err_s2;
	data_t  shres_s2, st_data_s2;
	data_t  mem_raw_s2;
	logic   mem_vld_s2;
	data_t  mem_val;
	reg_wr_t rf_wr;
	logic   mem_we;
	logic   done;
	result_t res;

	// Last committed writes, for same-edge forwarding
	reg_wr_t rf_wb_q;
	logic    mem_wb_en_q;
	logic [MEM_AW-1:0] mem_wb_addr_q;
	data_t   mem_wb_data_q;

	logic [CNT_W-1:0] cnt_q;

	// Result queue
	result_t fifo_mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_CW-1:0] fifo_cnt_q;
	logic [FIFO_CW-1:0] occupancy;
	logic fifo_pop;

	// Accept when queue plus in-flight transactions leave room
	assign in_ins    = instr_t'(s_tdata[$bits(instr_t)-1:0]);
	assign occupancy = fifo_cnt_q + FIFO_CW'(s1_v) + FIFO_CW'(s2_v);
	assign s_tready  = occupancy < FIFO_CW'(FIFO_DEPTH);
	assign in_acc    = s_tvalid && s_tready;

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else begin
			s1_v <= in_acc;
		end
	end

	// Register file read, both ports
	always_ff @(posedge clk) begin
		ins_s1    <= in_ins;
		rt_raw_s1 <= rf_mem[reg_addr(in_ins.target_reg)];
		rt_vld_s1 <= rf_vld_q[reg_addr(in_ins.target_reg)];
		ra_raw_s1 <= rf_mem[reg_addr(in_ins.addr_reg)];
		ra_vld_s1 <= rf_vld_q[reg_addr(in_ins.addr_reg)];
	end

	// Register operands with forwarding: stage 2 write first, then last committed write
	always_comb begin
		if (rf_wr.en && rf_wr.idx == ins_s1.target_reg) begin
			v_tgt = rf_wr.data;
		end else if (rf_wb_q.en && rf_wb_q.idx == ins_s1.target_reg) begin
			v_tgt = rf_wb_q.data;
		end else if (reg_in_range(ins_s1.target_reg) && rt_vld_s1) begin
			v_tgt = rt_raw_s1;
		end else begin
			v_tgt = '0;
		end

		if (rf_wr.en && rf_wr.idx == ins_s1.addr_reg) begin
			v_areg = rf_wr.data;
		end else if (rf_wb_q.en && rf_wb_q.idx == ins_s1.addr_reg) begin
			v_areg = rf_wb_q.data;
		end else if (reg_in_range(ins_s1.addr_reg) && ra_vld_s1) begin
			v_areg = ra_raw_s1;
		end else begin
			v_areg = '0;
		end
	end

	// Shift/rotate and address check
	always_comb begin
		dbl = {v_tgt, v_tgt};
		case (ins_s1.mode)
			MODE_SHL: shres = v_tgt << ins_s1.shift_amount;
			MODE_SHR: shres = v_tgt >> ins_s1.shift_amount;
			MODE_ROL: begin
				dbl   = dbl << ins_s1.shift_amount;
				shres = dbl[2*DATA_WIDTH-1:DATA_WIDTH];
			end
			MODE_ROR: begin
				dbl   = dbl >> ins_s1.shift_amount;
				shres = dbl[DATA_WIDTH-1:0];
			end
			default: shres = '0;
		endcase

		addr_full = ins_s1.use_indirect ? v_areg : DATA_WIDTH'(ins_s1.direct_addr);
		addr_err  = (ins_s1.mode == MODE_LOAD || ins_s1.mode == MODE_STORE) &&
			(int'(addr_full) >= MEM_WORDS);
	end

	// Stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else begin
			s2_v <= s1_v;
		end
	end

	// Stage 2 payload and data memory read
	always_ff @(posedge clk) begin
		mode_s2    <= ins_s1.mode;
		tgt_s2     <= ins_s1.target_reg;
		addr_s2    <= MEM_AW'(addr_full);
		err_s2     <= addr_err;
		shres_s2   <= shres;
		st_data_s2 <= v_tgt;
		mem_raw_s2 <= dmem[MEM_AW'(addr_full)];
		mem_vld_s2 <= dmem_vld_q[MEM_AW'(addr_full)];
	end

	// Memory data with forwarding of the store committed at the read edge
	always_comb begin
		if (mem_wb_en_q && mem_wb_addr_q == addr_s2) begin
			mem_val = mem_wb_data_q;
		end else if (mem_vld_s2) begin
			mem_val = mem_raw_s2;
		end else begin
			mem_val = mem_reset_val(addr_s2);
		end
	end

	// Writeback and result
	always_comb begin
		rf_wr.idx = tgt_s2;
		rf_wr.en  = 1'b0;
		rf_wr.data = shres_s2;
		mem_we    = 1'b0;
		done      = 1'b0;
		res.moved_value = '0;
		res.addr_error  = 1'b0;
		case (mode_s2)
			MODE_SHL, MODE_SHR, MODE_ROL, MODE_ROR: begin
				rf_wr.en  = s2_v && reg_in_range(tgt_s2);
				done      = 1'b1;
				res.moved_value = shres_s2;
			end
			MODE_LOAD: begin
				rf_wr.data = mem_val;
				if (err_s2) begin
					res.addr_error = 1'b1;
				end else begin
					rf_wr.en  = s2_v && reg_in_range(tgt_s2);
					done      = 1'b1;
					res.moved_value = mem_val;
				end
			end
			MODE_STORE: begin
				if (err_s2) begin
					res.addr_error = 1'b1;
				end else begin
					mem_we    = s2_v;
					done      = 1'b1;
					res.moved_value = st_data_s2;
				end
			end
			default: begin
				done = 1'b0;
			end
		endcase
		res.executed_count = done ? cnt_q + 1'b1 : cnt_q;
	end

	// Register file write
	always_ff @(posedge clk) begin
		if (rf_wr.en) begin
			rf_mem[reg_addr(rf_wr.idx)] <= rf_wr.data;
		end
	end

	// Data memory write
	always_ff @(posedge clk) begin
		if (mem_we) begin
			dmem[addr_s2] <= st_data_s2;
		end
	end

	// Written-entry flags, write records and counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rf_vld_q    <= '0;
			dmem_vld_q  <= '0;
			rf_wb_q     <= '0;
			mem_wb_en_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (rf_wr.en) begin
				rf_vld_q[reg_addr(rf_wr.idx)] <= 1'b1;
			end
			if (mem_we) begin
				dmem_vld_q[addr_s2] <= 1'b1;
			end
			rf_wb_q     <= rf_wr;
			mem_wb_en_q <= mem_we;
			if (s2_v && done) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		mem_wb_addr_q <= addr_s2;
		mem_wb_data_q <= st_data_s2;
	end

	// Result queue
	assign fifo_pop = m_tvalid && m_tready;
	assign m_tvalid = fifo_cnt_q != '0;
	assign m_tdata  = OUT_W'(fifo_mem[rd_ptr_q]);

	always_ff @(posedge clk) begin
		if (s2_v) begin
			fifo_mem[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (s2_v) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (fifo_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			fifo_cnt_q <= fifo_cnt_q + FIFO_CW'(s2_v) - FIFO_CW'(fifo_pop);
		end
	end

endmodule

// File: tb/srlsu_result_checker.sv
// Result checker for the shift/rotate/load/store unit testbench.
// Watches both stream channels, predicts every result and compares it field by field.
// Depends on srlsu_pkg.
module srlsu_result_checker
	import srlsu_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	input  logic             s_tready,
	// s_tdata: mode[2:0], target_reg[5:3], shift_amount[8:6], use_indirect[9],
	//          direct_addr[15:10], addr_reg[18:16], zero[23:19]
	input  logic [IN_W-1:0]  s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	// m_tdata: moved_value[7:0], addr_error[8], executed_count[24:9], zero[31:25]
	input  logic [OUT_W-1:0] m_tdata,
	output int               mismatches,
	output int               outstanding
);

	// Shadow of the unit's architectural state
	data_t            gpr [REG_COUNT];
	data_t            dmem [MEM_WORDS];
	logic [CNT_W-1:0] exec_count;
	result_t          awaited_results [$];
	int               results_seen;

	task automatic report_mismatch(input string what);
		$display("[%0t] result %0d: %s", $time, results_seen, what);
		mismatches++;
	endtask

	// Out-of-range register index reads as zero
	function automatic data_t read_gpr(logic [IDX_W-1:0] idx);
		return (int'(idx) < REG_COUNT) ? gpr[idx] : '0;
	endfunction

	function automatic void write_gpr(logic [IDX_W-1:0] idx, data_t val);
		if (int'(idx) < REG_COUNT)
			gpr[idx] = val;
	endfunction

	// Executes one instruction on the shadow state and returns its result
	function automatic result_t run_instruction(instr_t ins);
		result_t     res;
		logic [15:0] twin;
		data_t       val;
		int          addr;
		logic        counted;
		res = '0;
		counted = 1'b0;
		case (ins.mode)
			MODE_SHL, MODE_SHR, MODE_ROL, MODE_ROR: begin
				val = read_gpr(ins.target_reg);
				twin = {val, val};
				case (ins.mode)
					MODE_SHL: res.moved_value = val << ins.shift_amount;
					MODE_SHR: res.moved_value = val >> ins.shift_amount;
					MODE_ROL: res.moved_value = data_t'(twin >> (DATA_WIDTH - ins.shift_amount));
					default:  res.moved_value = data_t'(twin >> ins.shift_amount);
				endcase
				write_gpr(ins.target_reg, res.moved_value);
				counted = 1'b1;
			end
			MODE_LOAD, MODE_STORE: begin
				addr = ins.use_indirect ? int'(read_gpr(ins.addr_reg)) : int'(ins.direct_addr);
				if (addr >= MEM_WORDS) begin
					res.addr_error = 1'b1;
				end else if (ins.mode == MODE_LOAD) begin
					res.moved_value = dmem[addr];
					write_gpr(ins.target_reg, res.moved_value);
					counted = 1'b1;
				end else begin
					res.moved_value = read_gpr(ins.target_reg);
					dmem[addr] = res.moved_value;
					counted = 1'b1;
				end
			end
			// spare opcodes change nothing and are not counted
			default: ;
		endcase
		if (counted)
			exec_count = exec_count + 1'b1;
		res.executed_count = exec_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			foreach (gpr[i])
				gpr[i] = '0;
			foreach (dmem[i])
				dmem[i] = (i == RESET_WORD) ? data_t'(RESET_WORD_VAL) : '0;
			exec_count = '0;
			awaited_results.delete();
			results_seen = 0;
			mismatches = 0;
			outstanding <= 0;
		end else begin
			// result side first, so an instruction taken at this edge never matches itself
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[$bits(result_t)-1:0]);
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result 0x%h", m_tdata));
				end else begin
					want = awaited_results.pop_front();
					if (got.moved_value !== want.moved_value)
						report_mismatch($sformatf("moved_value %0d, want %0d",
							got.moved_value, want.moved_value));
					if (got.addr_error !== want.addr_error)
						report_mismatch($sformatf("addr_error %b, want %b",
							got.addr_error, want.addr_error));
					if (got.executed_count !== want.executed_count)
						report_mismatch($sformatf("executed_count %0d, want %0d",
							got.executed_count, want.executed_count));
				end
				if (m_tdata[OUT_W-1:$bits(result_t)] !== '0)
					report_mismatch("padding bits above executed_count not zero");
				results_seen++;
			end
			if (s_tvalid && s_tready)
				awaited_results.push_back(run_instruction(instr_t'(s_tdata[$bits(instr_t)-1:0])));
			outstanding <= awaited_results.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench top for shift_rotate_load_store_unit_core: clock, reset, instruction stimulus,
// random backpressure and the final verdict. Checking lives in srlsu_result_checker.
// Depends on srlsu_pkg, shift_rotate_load_store_unit_core and srlsu_result_checker.
module tb_top;
	import srlsu_pkg::*;

	// opcodes the unit does not implement
	localparam logic [2:0]       OP_SPARE_LO  = 3'd6;
	localparam logic [2:0]       OP_SPARE_HI  = 3'd7;
	// register index past the end of the register file
	localparam logic [IDX_W-1:0] NO_REG       = 3'd7;
	localparam int               TOTAL_ITEMS  = 1825;
	localparam int               STALL_CYCLES = 150;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;
	int               mismatches;
	int               outstanding;
	int               items_sent;
	int               results_taken;
	int               send_gap_max;
	int               take_gap_max;

	shift_rotate_load_store_unit_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	srlsu_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

	// idle ceiling for a stretch of transactions: none, light or heavy
	function automatic int pick_gap_max();
		case ($urandom_range(0, 2))
			0:       return 0;
			1:       return 4;
			default: return 18;
		endcase
	endfunction

	function automatic logic [IDX_W-1:0] rand_reg();
		if ($urandom_range(0, 9) == 0)
			return NO_REG;
		return IDX_W'($urandom_range(0, REG_COUNT - 1));
	endfunction

	// direct address that only rarely lands on the seeded word, so its bit survives
	function automatic logic [DADDR_W-1:0] store_addr();
		int a;
		a = $urandom_range(0, 63);
		if (a == RESET_WORD && $urandom_range(0, 99) != 0)
			a = a + 1;
		return DADDR_W'(a);
	endfunction

	// Offers one instruction after a random gap and waits for the handshake
	task automatic issue(input logic [2:0] op, input logic [IDX_W-1:0] tgt,
			input logic [SHIFT_W-1:0] sh, input logic ind,
			input logic [DADDR_W-1:0] daddr, input logic [IDX_W-1:0] areg);
		int gap;
		if (items_sent % 64 == 0)
			send_gap_max = pick_gap_max();
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'b0, areg, daddr, ind, sh, tgt, op};
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// Receiver: random stalls per result, two long hold-offs to fill the unit
	initial begin : take_results
		int wait_cycles;
		m_tready <= 1'b0;
		results_taken = 0;
		take_gap_max = 0;
		@(posedge arst_n);
		forever begin
			if (results_taken % 64 == 0)
				take_gap_max = pick_gap_max();
			if (results_taken == 200 || results_taken == 1100)
				wait_cycles = STALL_CYCLES;
			else
				wait_cycles = $urandom_range(0, take_gap_max);
			if (wait_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			results_taken++;
		end
	end

	// Sender: reset, directed instructions, then random sequences
	initial begin : make_stimulus
		logic [IDX_W-1:0] ptr;
		logic [IDX_W-1:0] tmp;
		logic [2:0]       op;
		logic             ind;
		logic [DADDR_W-1:0] daddr;
		int               steps;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		items_sent = 0;
		send_gap_max = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// seeded word, rotations up to error addresses, out-of-range registers
		issue(MODE_LOAD,  3'd0, 3'd0, 1'b0, 6'(RESET_WORD), 3'd0);
		issue(MODE_SHL,   3'd0, 3'd0, 1'b0, 6'd0,  3'd0);
		issue(MODE_ROL,   3'd0, 3'd4, 1'b0, 6'd0,  3'd0);
		issue(MODE_LOAD,  3'd1, 3'd0, 1'b1, 6'd0,  3'd0);
		issue(MODE_STORE, 3'd1, 3'd0, 1'b1, 6'd0,  3'd0);
		issue(MODE_ROL,   3'd0, 3'd1, 1'b0, 6'd0,  3'd0);
		issue(MODE_ROR,   3'd0, 3'd0, 1'b0, 6'd0,  3'd0);
		issue(MODE_STORE, 3'd0, 3'd0, 1'b0, 6'd63, 3'd0);
		issue(MODE_LOAD,  NO_REG, 3'd0, 1'b0, 6'd63, 3'd0);
		issue(MODE_STORE, NO_REG, 3'd0, 1'b0, 6'd0, 3'd0);
		issue(MODE_ROR,   3'd0, 3'd7, 1'b0, 6'd0,  3'd0);
		issue(MODE_LOAD,  3'd2, 3'd0, 1'b0, 6'(RESET_WORD), 3'd0);
		issue(MODE_SHR,   3'd2, 3'd2, 1'b0, 6'd0,  3'd0);
		issue(MODE_SHL,   3'd2, 3'd7, 1'b0, 6'd0,  3'd0);
		issue(MODE_SHR,   3'd2, 3'd7, 1'b0, 6'd0,  3'd0);
		issue(MODE_ROL,   3'd2, 3'd7, 1'b0, 6'd0,  3'd0);
		issue(MODE_STORE, 3'd2, 3'd0, 1'b1, 6'd0,  3'd0);
		issue(MODE_LOAD,  3'd3, 3'd0, 1'b1, 6'd0,  NO_REG);
		issue(OP_SPARE_LO, 3'd7, 3'd7, 1'b1, 6'd63, 3'd7);
		issue(OP_SPARE_HI, 3'd7, 3'd7, 1'b1, 6'd63, 3'd7);
		issue(MODE_LOAD,  3'd6, 3'd0, 1'b1, 6'd0,  3'd0);
		issue(MODE_STORE, 3'd6, 3'd5, 1'b0, 6'd62, 3'd7);
		issue(MODE_LOAD,  3'd5, 3'd0, 1'b0, 6'(RESET_WORD), 3'd0);
		issue(MODE_STORE, 3'd5, 3'd0, 1'b0, 6'(RESET_WORD), 3'd0);
		issue(MODE_SHR,   3'd6, 3'd7, 1'b0, 6'd0,  3'd0);

		while (items_sent < TOTAL_ITEMS) begin
			case ($urandom_range(0, 3))
				0, 1: begin
					// pointer chain: fetch a byte, move its bit, then address memory with it
					ptr = rand_reg();
					daddr = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
						: 6'(RESET_WORD);
					issue(MODE_LOAD, ptr, 3'($urandom), 1'b0, daddr, 3'($urandom));
					steps = $urandom_range(1, 3);
					repeat (steps)
						issue(3'($urandom_range(0, 3)), ptr, 3'($urandom), 1'($urandom),
							6'($urandom), 3'($urandom));
					steps = $urandom_range(1, 3);
					repeat (steps) begin
						op = $urandom_range(0, 1) ? MODE_LOAD : MODE_STORE;
						issue(op, rand_reg(), 3'($urandom), 1'b1, 6'($urandom), ptr);
					end
				end
				2: begin
					// copy a byte from one direct address to another
					tmp = rand_reg();
					issue(MODE_LOAD, tmp, 3'($urandom), 1'b0, 6'($urandom), 3'($urandom));
					issue(MODE_STORE, tmp, 3'($urandom), 1'b0, store_addr(), 3'($urandom));
				end
				default: begin
					// noise: any opcode, any fields
					op = 3'($urandom);
					ind = 1'($urandom);
					daddr = (op == MODE_STORE && !ind) ? store_addr() : 6'($urandom);
					issue(op, 3'($urandom), 3'($urandom), ind, daddr, 3'($urandom));
				end
			endcase
		end
		s_tvalid <= 1'b0;

		// drain, then let the pipeline settle
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: shift_rotate_load_store_unit_core.f
hw/rtl/srlsu_pkg.sv
hw/rtl/shift_rotate_load_store_unit_core.sv
tb/srlsu_result_checker.sv
tb/tb_top.sv
